/* sv/scl_pkg.sv */
// Shared types, keyword tables and command codes for the command line parser.
`timescale 1ns / 1ps

package scl_pkg;

    localparam int NKW = 8;
    localparam int KW_IDX_W = 3;

    localparam logic [7:0] SEP_CHAR = 8'd32;
    localparam logic [7:0] DIGIT_LO = "0";
    localparam logic [7:0] DIGIT_HI = "9";

    localparam logic [KW_IDX_W-1:0] KW_HELP    = 3'd0;
    localparam logic [KW_IDX_W-1:0] KW_US      = 3'd1;
    localparam logic [KW_IDX_W-1:0] KW_DELAY   = 3'd2;
    localparam logic [KW_IDX_W-1:0] KW_STATUS  = 3'd3;
    localparam logic [KW_IDX_W-1:0] KW_UNIT    = 3'd4;
    localparam logic [KW_IDX_W-1:0] KW_ONESHOT = 3'd5;
    localparam logic [KW_IDX_W-1:0] KW_OFF     = 3'd6;
    localparam logic [KW_IDX_W-1:0] KW_ON      = 3'd7;

    // keyword text, right aligned, first character in the highest used byte
    localparam logic [63:0] KW_TEXT [NKW] = '{
        64'("help"), 64'("us"), 64'("delay"), 64'("status"),
        64'("unit"), 64'("one-shot"), 64'("off"), 64'("on")
    };
    localparam logic [3:0] KW_LEN [NKW] = '{
        4'd4, 4'd2, 4'd5, 4'd6, 4'd4, 4'd8, 4'd3, 4'd2
    };

    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_HELP   = 3'd1;
    localparam logic [2:0] CMD_LIST   = 3'd2;
    localparam logic [2:0] CMD_DELAY  = 3'd3;
    localparam logic [2:0] CMD_STATUS = 3'd4;
    localparam logic [2:0] CMD_UNIT   = 3'd5;
    localparam logic [2:0] CMD_MODE   = 3'd6;

    // token state after the current byte, before end-of-token clearing
    typedef struct packed {
        logic [3:0]     cpos;
        logic [NKW-1:0] mask;
        logic           all_dig;
        logic [7:0]     ufc;
        logic           end_tok;
    } tok_flags_t;

    function automatic logic [7:0] kw_char(input logic [KW_IDX_W-1:0] k,
                                           input logic [2:0] pos);
        int sh;
        logic [63:0] s;
        sh = (int'(KW_LEN[k]) - 1 - int'(pos)) * 8;
        s = (sh < 0) ? 64'd0 : (KW_TEXT[k] >> sh);
        return s[7:0];
    endfunction

endpackage

/* sv/scl_token.sv */
// Per-token tracking: position, keyword match mask, digit flag, accumulator.
`timescale 1ns / 1ps

module scl_token #(
    parameter int ACC_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        ch,
    input  logic              last,
    output scl_pkg::tok_flags_t tn,
    output logic [ACC_W-1:0]  acc_next
);
    import scl_pkg::*;

    logic [3:0]       cpos_reg;
    logic [NKW-1:0]   mask_reg;
    logic             all_dig_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [7:0]       ufc_reg;

    logic             is_sep;
    logic             first;
    logic             is_digit;
    logic [NKW-1:0]   mask_base;
    logic [NKW-1:0]   keep;
    logic             dig_base;
    logic [ACC_W-1:0] acc_base;
    logic [ACC_W+3:0] prod;

    always_comb
    begin
        is_sep    = (ch == SEP_CHAR);
        first     = (cpos_reg == 4'd0);
        is_digit  = (ch >= DIGIT_LO) && (ch <= DIGIT_HI);
        mask_base = first ? '1 : mask_reg;
        dig_base  = first ? 1'b1 : all_dig_reg;
        acc_base  = first ? '0 : acc_reg;
        for (int k = 0; k < NKW; k++)
        begin
            keep[k] = (cpos_reg < KW_LEN[k]) &&
                      (kw_char(KW_IDX_W'(k), cpos_reg[2:0]) == ch);
        end
        prod = ({4'd0, acc_base} << 3) + ({4'd0, acc_base} << 1)
             + (ACC_W+4)'(ch[3:0]);

        tn = '{cpos: cpos_reg, mask: mask_reg, all_dig: all_dig_reg,
               ufc: ufc_reg, end_tok: 1'b0};
        acc_next = acc_reg;
        if (!is_sep)
        begin
            tn.cpos    = (cpos_reg == 4'hF) ? cpos_reg : cpos_reg + 4'd1;
            tn.mask    = mask_base & keep;
            tn.all_dig = dig_base & is_digit;
            tn.ufc     = first ? ch : ufc_reg;
            if (is_digit)
            begin
                acc_next = (|prod[ACC_W+3:ACC_W]) ? '1 : prod[ACC_W-1:0];
            end
            else
            begin
                acc_next = acc_base;
            end
        end
        // a separator ends a started token; a last byte that is not a separator always ends one
        tn.end_tok = is_sep ? !first : last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpos_reg    <= 4'd0;
            mask_reg    <= '1;
            all_dig_reg <= 1'b1;
            acc_reg     <= '0;
            ufc_reg     <= 8'd0;
        end
        else if (take)
        begin
            cpos_reg    <= (tn.end_tok || last) ? 4'd0 : tn.cpos;
            mask_reg    <= tn.mask;
            all_dig_reg <= tn.all_dig;
            acc_reg     <= acc_next;
            ufc_reg     <= tn.ufc;
        end
    end

endmodule

/* sv/scl_parse.sv */
// Command grammar sequencer and stored sensor settings.
`timescale 1ns / 1ps

module scl_parse #(
    parameter int ACC_W = 16,
    parameter int ID_W  = 8,
    parameter int VAL_W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic                last,
    input  scl_pkg::tok_flags_t tn,
    input  logic [ACC_W-1:0]    acc_next,
    output logic [2:0]          cmd,
    output logic [ID_W-1:0]     sid_next,
    output logic [VAL_W-1:0]    delay_next,
    output logic [1:0]          unit_next,
    output logic [1:0]          mode_next,
    output logic [VAL_W-1:0]    period_next
);
    import scl_pkg::*;

    typedef enum logic [6:0] {
        ST_FIRST    = 7'b0000001,
        ST_ID       = 7'b0000010,
        ST_SUB      = 7'b0000100,
        ST_DELAYNUM = 7'b0001000,
        ST_UNITCH   = 7'b0010000,
        ST_ONNUM    = 7'b0100000,
        ST_DONE     = 7'b1000000
    } stage_t;

    localparam logic [1:0] UNIT_IN  = 2'd0;
    localparam logic [1:0] UNIT_CM  = 2'd1;
    localparam logic [1:0] UNIT_US  = 2'd2;
    localparam logic [1:0] MODE_ONE = 2'd0;
    localparam logic [1:0] MODE_OFF = 2'd1;
    localparam logic [1:0] MODE_PER = 2'd2;

    localparam logic [ACC_W-1:0] ID_CAP  = ACC_W'((64'd1 << ID_W) - 64'd1);
    localparam logic [ACC_W-1:0] VAL_CAP = ACC_W'((64'd1 << VAL_W) - 64'd1);

    stage_t            stage_reg, stage_next;
    logic [2:0]        pend_reg, pend_next;
    logic [ID_W-1:0]   sid_reg;
    logic [VAL_W-1:0]  delay_reg;
    logic [1:0]        unit_reg;
    logic [1:0]        mode_reg;
    logic [VAL_W-1:0]  period_reg;

    logic [NKW-1:0]    hit;
    logic [ID_W-1:0]   id_clip;
    logic [VAL_W-1:0]  val_clip;

    always_comb
    begin
        for (int k = 0; k < NKW; k++)
        begin
            hit[k] = tn.mask[k] && (tn.cpos == KW_LEN[k]);
        end
        id_clip  = (acc_next > ID_CAP) ? ID_CAP[ID_W-1:0] : acc_next[ID_W-1:0];
        val_clip = (acc_next > VAL_CAP) ? VAL_CAP[VAL_W-1:0] : acc_next[VAL_W-1:0];

        stage_next  = stage_reg;
        pend_next   = pend_reg;
        sid_next    = sid_reg;
        delay_next  = delay_reg;
        unit_next   = unit_reg;
        mode_next   = mode_reg;
        period_next = period_reg;

        if (tn.end_tok)
        begin
            unique case (stage_reg)
                ST_FIRST:
                begin
                    if (hit[KW_HELP])
                    begin
                        stage_next = ST_DONE;
                        pend_next  = CMD_HELP;
                    end
                    else if (hit[KW_US])
                    begin
                        stage_next = ST_ID;
                    end
                    else
                    begin
                        stage_next = ST_DONE;
                        pend_next  = CMD_NONE;
                    end
                end
                ST_ID:
                begin
                    if (tn.all_dig)
                    begin
                        sid_next   = id_clip;
                        stage_next = ST_SUB;
                    end
                    else
                    begin
                        stage_next = ST_DONE;
                        pend_next  = CMD_NONE;
                    end
                end
                ST_SUB:
                begin
                    stage_next = ST_DONE;
                    pend_next  = CMD_NONE;
                    if (hit[KW_DELAY])
                    begin
                        stage_next = ST_DELAYNUM;
                    end
                    else if (hit[KW_STATUS])
                    begin
                        pend_next = CMD_STATUS;
                    end
                    else if (hit[KW_UNIT])
                    begin
                        stage_next = ST_UNITCH;
                    end
                    else if (hit[KW_ONESHOT])
                    begin
                        mode_next = MODE_ONE;
                        pend_next = CMD_MODE;
                    end
                    else if (hit[KW_OFF])
                    begin
                        mode_next = MODE_OFF;
                        pend_next = CMD_MODE;
                    end
                    else if (hit[KW_ON])
                    begin
                        stage_next = ST_ONNUM;
                    end
                end
                ST_DELAYNUM:
                begin
                    stage_next = ST_DONE;
                    pend_next  = CMD_NONE;
                    if (tn.all_dig)
                    begin
                        delay_next = val_clip;
                        pend_next  = CMD_DELAY;
                    end
                end
                ST_UNITCH:
                begin
                    stage_next = ST_DONE;
                    pend_next  = CMD_UNIT;
                    case (tn.ufc)
                        "i":     unit_next = UNIT_IN;
                        "c":     unit_next = UNIT_CM;
                        "m":     unit_next = UNIT_US;
                        default: pend_next = CMD_NONE;
                    endcase
                end
                ST_ONNUM:
                begin
                    stage_next = ST_DONE;
                    pend_next  = CMD_NONE;
                    if (tn.all_dig)
                    begin
                        mode_next   = MODE_PER;
                        period_next = val_clip;
                        pend_next   = CMD_MODE;
                    end
                end
                ST_DONE:
                begin
                    stage_next = ST_DONE;
                end
                default:
                begin
                    stage_next = ST_DONE;
                    pend_next  = CMD_NONE;
                end
            endcase
        end

        if (stage_next == ST_DONE)
        begin
            cmd = pend_next;
        end
        else if (stage_next == ST_ID)
        begin
            cmd = CMD_LIST;
        end
        else
        begin
            cmd = CMD_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg  <= ST_FIRST;
            pend_reg   <= CMD_NONE;
            sid_reg    <= '0;
            delay_reg  <= '0;
            unit_reg   <= UNIT_IN;
            mode_reg   <= MODE_ONE;
            period_reg <= '0;
        end
        else if (take)
        begin
            stage_reg  <= last ? ST_FIRST : stage_next;
            pend_reg   <= last ? CMD_NONE : pend_next;
            sid_reg    <= sid_next;
            delay_reg  <= delay_next;
            unit_reg   <= unit_next;
            mode_reg   <= mode_next;
            period_reg <= period_next;
        end
    end

endmodule

/* sv/sensor_command_line_parser_top.sv */
// Top level of the sensor command line parser.
//
//  group  | dir | payload (lowest bit first)                         | item
//  s_axis | in  | tdata: ch[7:0]; tlast: last                        | one line byte
//  m_axis | out | tdata: command, sensor_id, delay_ms, unit, mode,   | one per line
//         |     |        period_ms, zero fill to whole bytes         |
//
// One byte is accepted per cycle while s_tready is high; the byte state updates in the cycle it is taken.
// A byte with tlast gives its result on m_tdata in the next cycle.
// The output register holds a result until taken; s_tready drops only while a
// result is held and m_tready is low.
// rst_n resets the line state and clears the stored settings to zero.
`timescale 1ns / 1ps

module sensor_command_line_parser_top #(
    parameter int VALUE_WIDTH = 16,
    parameter int ID_WIDTH    = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // ch[7:0]
    input  logic            s_tlast,
    output logic            m_tvalid,
    input  logic            m_tready,
    // command[2:0], sensor_id, delay_ms, unit[1:0], mode[1:0], period_ms, zero fill
    output logic [((7 + ID_WIDTH + 2 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);
    import scl_pkg::*;

    localparam int ACC_W  = (VALUE_WIDTH > ID_WIDTH) ? VALUE_WIDTH : ID_WIDTH;
    localparam int USED_W = 7 + ID_WIDTH + 2 * VALUE_WIDTH;
    localparam int OUT_W  = ((USED_W + 7) / 8) * 8;

    tok_flags_t             tn;
    logic [ACC_W-1:0]       acc_next;
    logic                   take;
    logic [2:0]             cmd;
    logic [ID_WIDTH-1:0]    sid_next;
    logic [VALUE_WIDTH-1:0] delay_next;
    logic [1:0]             unit_next;
    logic [1:0]             mode_next;
    logic [VALUE_WIDTH-1:0] period_next;
    logic                   m_valid_reg;
    logic [OUT_W-1:0]       m_data_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    scl_token #(
        .ACC_W (ACC_W)
    ) u_token (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .ch       (s_tdata),
        .last     (s_tlast),
        .tn       (tn),
        .acc_next (acc_next)
    );

    scl_parse #(
        .ACC_W (ACC_W),
        .ID_W  (ID_WIDTH),
        .VAL_W (VALUE_WIDTH)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .last        (s_tlast),
        .tn          (tn),
        .acc_next    (acc_next),
        .cmd         (cmd),
        .sid_next    (sid_next),
        .delay_next  (delay_next),
        .unit_next   (unit_next),
        .mode_next   (mode_next),
        .period_next (period_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (take && s_tlast)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && s_tlast)
        begin
            m_data_reg <= OUT_W'({period_next, mode_next, unit_next,
                                  delay_next, sid_next, cmd});
        end
    end

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result appeared without a last byte");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("last byte gave no result");

    a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= CMD_MODE))
        else $error("command code out of range");

endmodule

/* bench/scl_result_checker.sv */
// Command line parser checker: predicts each line's result from the accepted bytes and compares.
`timescale 1ns / 1ps

module scl_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // command[2:0], sensor_id[7:0], delay_ms[15:0], unit[1:0], mode[1:0], period_ms[15:0], fill
    input  logic [47:0] m_tdata,
    output int          errors,
    output int          pending
);
    import scl_pkg::*;

    localparam int unsigned ID_MAX    = 255;
    localparam int unsigned VALUE_MAX = 65535;
    localparam int unsigned ACC_MAX   = VALUE_MAX;
    localparam int unsigned POS_MAX   = 15;

    typedef enum logic [2:0] {
        AT_FIRST, AT_ID, AT_SUB, AT_DELAY_NUM, AT_UNIT_CHAR, AT_ON_NUM, AT_DONE
    } parse_stage_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  sensor_id;
        logic [15:0] delay_ms;
        logic [1:0]  unit;
        logic [1:0]  mode;
        logic [15:0] period_ms;
    } line_result_t;

    logic [7:0]   word_chars [0:15];
    int unsigned  word_len;
    logic         digits_only;
    int unsigned  number_acc;
    logic [7:0]   unit_letter;
    parse_stage_t stage;
    logic [2:0]   cmd_due;
    logic [7:0]   kept_id;
    logic [15:0]  kept_delay;
    logic [1:0]   kept_unit;
    logic [1:0]   kept_mode;
    logic [15:0]  kept_period;
    line_result_t results_due [$];
    int           err_count;

    function automatic logic word_is(input string w);
        int i;
        if (word_len != w.len())
            return 1'b0;
        for (i = 0; i < w.len(); i++)
            if (word_chars[i] != w[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic conclude(input logic [2:0] cmd);
        stage   = AT_DONE;
        cmd_due = cmd;
    endtask

    task automatic take_token_byte(input logic [7:0] c);
        if (word_len == 0)
        begin
            digits_only = 1'b1;
            number_acc  = 0;
            unit_letter = c;
        end
        if (c >= DIGIT_LO && c <= DIGIT_HI)
        begin
            number_acc = number_acc * 10 + (int'(c) - int'(DIGIT_LO));
            if (number_acc > ACC_MAX)
                number_acc = ACC_MAX;
        end
        else
            digits_only = 1'b0;
        if (word_len < POS_MAX)
        begin
            word_chars[word_len] = c;
            word_len++;
        end
    endtask

    task automatic close_token();
        case (stage)
            AT_FIRST:
                if (word_is("help"))
                    conclude(CMD_HELP);
                else if (word_is("us"))
                    stage = AT_ID;
                else
                    conclude(CMD_NONE);
            AT_ID:
                if (digits_only)
                begin
                    kept_id = (number_acc > ID_MAX) ? 8'(ID_MAX) : 8'(number_acc);
                    stage   = AT_SUB;
                end
                else
                    conclude(CMD_NONE);
            AT_SUB:
                if (word_is("delay"))
                    stage = AT_DELAY_NUM;
                else if (word_is("status"))
                    conclude(CMD_STATUS);
                else if (word_is("unit"))
                    stage = AT_UNIT_CHAR;
                else if (word_is("one-shot"))
                begin
                    kept_mode = 2'd0;
                    conclude(CMD_MODE);
                end
                else if (word_is("off"))
                begin
                    kept_mode = 2'd1;
                    conclude(CMD_MODE);
                end
                else if (word_is("on"))
                    stage = AT_ON_NUM;
                else
                    conclude(CMD_NONE);
            AT_DELAY_NUM:
                if (digits_only)
                begin
                    kept_delay = 16'(number_acc);
                    conclude(CMD_DELAY);
                end
                else
                    conclude(CMD_NONE);
            AT_UNIT_CHAR:
                if (unit_letter == "i")
                begin
                    kept_unit = 2'd0;
                    conclude(CMD_UNIT);
                end
                else if (unit_letter == "c")
                begin
                    kept_unit = 2'd1;
                    conclude(CMD_UNIT);
                end
                else if (unit_letter == "m")
                begin
                    kept_unit = 2'd2;
                    conclude(CMD_UNIT);
                end
                else
                    conclude(CMD_NONE);
            AT_ON_NUM:
                if (digits_only)
                begin
                    kept_mode   = 2'd2;
                    kept_period = 16'(number_acc);
                    conclude(CMD_MODE);
                end
                else
                    conclude(CMD_NONE);
            default:
                ;
        endcase
        word_len = 0;
    endtask

    task automatic model_line_byte(input logic [7:0] c, input logic is_last);
        line_result_t r;
        if (c != SEP_CHAR)
            take_token_byte(c);
        else if (word_len != 0)
            close_token();
        if (is_last)
        begin
            if (word_len != 0)
                close_token();
            if (stage == AT_DONE)
                r.command = cmd_due;
            else if (stage == AT_ID)
                r.command = CMD_LIST;
            else
                r.command = CMD_NONE;
            r.sensor_id = kept_id;
            r.delay_ms  = kept_delay;
            r.unit      = kept_unit;
            r.mode      = kept_mode;
            r.period_ms = kept_period;
            results_due.push_back(r);
            stage    = AT_FIRST;
            cmd_due  = CMD_NONE;
            word_len = 0;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_result_t exp_r;
        if (!rst_n)
        begin
            word_len    = 0;
            digits_only = 1'b1;
            number_acc  = 0;
            unit_letter = 8'd0;
            stage       = AT_FIRST;
            cmd_due     = CMD_NONE;
            kept_id     = '0;
            kept_delay  = '0;
            kept_unit   = '0;
            kept_mode   = '0;
            kept_period = '0;
            results_due.delete();
            err_count   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                model_line_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    err_count++;
                end
                else
                begin
                    exp_r = results_due.pop_front();
                    check_field("command",   exp_r.command,   m_tdata[2:0]);
                    check_field("sensor_id", exp_r.sensor_id, m_tdata[10:3]);
                    check_field("delay_ms",  exp_r.delay_ms,  m_tdata[26:11]);
                    check_field("unit",      exp_r.unit,      m_tdata[28:27]);
                    check_field("mode",      exp_r.mode,      m_tdata[30:29]);
                    check_field("period_ms", exp_r.period_ms, m_tdata[46:31]);
                end
            end
        end
        errors  <= err_count;
        pending <= results_due.size();
    end

endmodule

/* bench/sensor_command_line_parser_top_test.sv */
// Testbench top for the sensor command line parser: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module sensor_command_line_parser_top_test;
    import scl_pkg::*;

    localparam int LINE_BYTES = 1500;
    localparam int LONG_HOLD  = 300;
    localparam int CYCLE_MAX  = 400000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    int          errors;
    int          pending;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    int          send_calm = 0;
    logic        hold_request = 1'b0;
    logic [7:0]  line_buf [$];

    string odd_words [8] = '{"onx", "dela", "statuss", "o", "oneshot", "HELP", "of", "unitt"};

    sensor_command_line_parser_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    scl_result_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_MAX)
        begin
            $display("sensor_command_line_parser_top_test: errors");
            $finish;
        end
    end

    task automatic drive_byte(input logic [7:0] c, input logic is_last);
        int gap;
        if (send_calm > 0)
        begin
            gap = 0;
            send_calm--;
        end
        else
        begin
            if ($urandom_range(0, 7) == 0)
                send_calm = $urandom_range(10, 40);
            gap = $urandom_range(0, 5);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_buf.size(); i++)
            drive_byte(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic add_spaces(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) line_buf.push_back(SEP_CHAR);
    endtask

    task automatic add_number();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
        repeat (n) line_buf.push_back(8'(DIGIT_LO + $urandom_range(0, 9)));
    endtask

    task automatic send_text(input string s);
        line_buf.delete();
        add_text(s);
        send_line();
    endtask

    // mostly valid "help" / "us <id> <sub> [arg]" lines with random separators
    task automatic build_command();
        int sub;
        string letters;
        letters = "icmxZ";
        add_spaces(0, $urandom_range(0, 1) * 2);
        if ($urandom_range(0, 9) == 0)
            add_text("help");
        else
        begin
            add_text("us");
            if ($urandom_range(0, 9) != 0)
            begin
                add_spaces(1, 3);
                add_number();
                sub = $urandom_range(0, 7);
                if (sub != 7)
                    add_spaces(1, 3);
                case (sub)
                    0:
                    begin
                        add_text("delay");
                        if ($urandom_range(0, 9) != 0)
                        begin
                            add_spaces(1, 3);
                            add_number();
                        end
                    end
                    1: add_text("status");
                    2:
                    begin
                        add_text("unit");
                        if ($urandom_range(0, 9) != 0)
                        begin
                            add_spaces(1, 3);
                            line_buf.push_back(letters[$urandom_range(0, 4)]);
                            repeat ($urandom_range(0, 3))
                                line_buf.push_back(8'($urandom_range(97, 122)));
                        end
                    end
                    3: add_text("one-shot");
                    4: add_text("off");
                    5:
                    begin
                        add_text("on");
                        if ($urandom_range(0, 9) != 0)
                        begin
                            add_spaces(1, 3);
                            add_number();
                        end
                    end
                    6: add_text(odd_words[$urandom_range(0, 7)]);
                    default: ;
                endcase
            end
        end
        if ($urandom_range(0, 4) == 0)
        begin
            add_spaces(1, 2);
            add_text(odd_words[$urandom_range(0, 7)]);
        end
        if ($urandom_range(0, 3) == 0)
            add_spaces(1, 3);
    endtask

    task automatic build_random_line();
        int shape;
        int n;
        line_buf.delete();
        shape = $urandom_range(0, 99);
        if (shape < 70)
            build_command();
        else if (shape < 82)
        begin
            // broken: possibly truncated and possibly one byte corrupted
            build_command();
            n = $urandom_range(0, line_buf.size() - 1);
            repeat (n) void'(line_buf.pop_back());
            if ($urandom_range(0, 1) == 1)
                line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else if (shape < 97)
        begin
            n = $urandom_range(1, 20);
            repeat (n)
                line_buf.push_back(($urandom_range(0, 3) == 0) ? SEP_CHAR
                                                              : 8'($urandom_range(0, 255)));
        end
        else
            add_spaces(1, 4);
    endtask

    initial
    begin : result_sink
        int stall;
        int calm;
        calm = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            if (calm > 0)
            begin
                stall = 0;
                calm--;
            end
            else
            begin
                if ($urandom_range(0, 7) == 0)
                    calm = $urandom_range(10, 40);
                stall = $urandom_range(0, 5);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tlast  <= 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("help");
        send_text("us");
        send_text("us 7");
        send_text("us 300 delay 70000");
        send_text("us 255 status");
        send_text("us 3 unit cm");
        send_text("us 3 unit mic");
        send_text("us 3 unit inch");
        send_text("us 3 unit x");
        send_text("us 12 unit");
        send_text("us 4 one-shot");
        send_text("us 4 off");
        send_text("us 4 on 65535");
        send_text("us 4 on");
        send_text("us 9 delay");
        send_text("us x delay 5");
        send_text("us 1 delay 12a");
        send_text("foo");
        send_text("us 2 bogus");
        send_text("help extra words");
        send_text("   ");
        send_text("  us   0   delay   0  ");
        send_text("us 00000000000000000012 one-shotttttttttttt");
        send_text("helpxxxxxxxxxxxxxxxxxxx");
        line_buf.delete();
        add_text("us ");
        line_buf.push_back(8'd0);
        line_buf.push_back(8'd255);
        add_text(" ");
        line_buf.push_back(8'd0);
        send_line();

        hold_request = 1'b1;
        while (bytes_sent < LINE_BYTES)
        begin
            build_random_line();
            send_line();
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("sensor_command_line_parser_top_test: clean");
        else
            $display("sensor_command_line_parser_top_test: errors");
        $finish;
    end

endmodule
